[src/piecewise_linear_interpolator_assert.svh]
// assertion macros for the piecewise linear interpolator checker
// expects signals named clock and reset in the scope of use

`ifndef PIECEWISE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_ASSERT_SVH

// same-cycle implication, off during reset
`define PLIN_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("plin check failed");

// next-cycle implication, off during reset
`define PLIN_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("plin check failed");

`endif

[src/plin_pkg.sv]
// shared types, constants and codes of the piecewise linear interpolator
// no dependencies
`default_nettype none

package plin_pkg;

   localparam int MAX_POINTS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int DATA_W     = 32;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int DIV_STEPS  = DATA_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [KIND_W-1:0] KIND_START  = KIND_W'(0);
   localparam logic [KIND_W-1:0] KIND_APPEND = KIND_W'(1);
   localparam logic [KIND_W-1:0] KIND_QUERY  = KIND_W'(2);

   localparam logic [STATUS_W-1:0] ST_OK     = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] ST_REJECT = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] ST_FEW    = STATUS_W'(2);

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic [DATA_W-1:0]        time_arg;
      logic signed [DATA_W-1:0] value_arg;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic [STATUS_W-1:0]      status;
   } rsp_type;

   typedef enum logic [2:0] {
      RSP_OK     = 3'd0,
      RSP_REJECT = 3'd1,
      RSP_FEW    = 3'd2,
      RSP_LAST   = 3'd3,
      RSP_INTERP = 3'd4
   } rsp_sel_type;

   // controller to datapath
   typedef struct packed {
      logic        capture;
      logic        write_start;
      logic        write_append;
      logic        rd_last;
      logic        scan_init;
      logic        scan_step;
      logic        load_ops;
      logic        mul;
      logic        div_step;
      logic        rsp_load;
      rsp_sel_type rsp_sel;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              count_zero;
      logic              count_full;
      logic              count_few;
      logic              time_le_rd;
      logic              j_zero;
      logic              j_at_last;
      logic              div_last;
   } stat_type;

endpackage

`default_nettype wire

[src/plin_datapath.sv]
// breakpoint table, scan registers, multiplier and restoring divider
// depends on plin_pkg
`default_nettype none

module plin_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire plin_pkg::req_type req_word,
   input  wire plin_pkg::cmd_type cmd,
   output plin_pkg::stat_type     stat,
   output plin_pkg::rsp_type      rsp_word
);

   localparam int DW = plin_pkg::DATA_W;
   localparam int IW = plin_pkg::IDX_W;
   localparam int CW = plin_pkg::CNT_W;
   localparam int VW = plin_pkg::DIV_CNT_W;

   logic [DW-1:0]          mem_time_ff  [plin_pkg::MAX_POINTS];
   logic [DW-1:0]          mem_value_ff [plin_pkg::MAX_POINTS];

   plin_pkg::req_type      req_ff;
   plin_pkg::rsp_type      rsp_ff;
   plin_pkg::rsp_type      rsp_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [IW-1:0]          j_ff, j_in;
   logic [DW-1:0]          rd_time_ff, rd_value_ff;
   logic [DW-1:0]          prev_time_ff, prev_value_ff;
   logic [DW-1:0]          lo_value_ff, dt_ff, span_ff, mag_ff;
   logic                   neg_ff, span_zero_ff;
   logic [DW-1:0]          rem_ff, quo_ff;
   logic [VW-1:0]          div_cnt_ff;

   logic [CW-1:0]          last_cnt;
   logic [IW-1:0]          last_idx;
   logic                   rd_en;
   logic [IW-1:0]          rd_addr;
   logic                   wr_en;
   logic [IW-1:0]          wr_addr;
   logic [DW-1:0]          wr_time, wr_value;
   logic [DW:0]            range_ext, mag_ext, shifted, diff, q_ext, lo_ext, sum_ext;
   logic                   ge;

   assign last_cnt = count_ff - CW'(1);
   assign last_idx = last_cnt[IW-1:0];

   // read port select
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      j_in    = j_ff;
      priority if (cmd.rd_last) begin
         rd_en   = 1'b1;
         rd_addr = last_idx;
      end else if (cmd.scan_init) begin
         rd_en   = 1'b1;
         rd_addr = '0;
         j_in    = '0;
      end else if (cmd.scan_step) begin
         rd_en   = 1'b1;
         rd_addr = j_ff + IW'(1);
         j_in    = j_ff + IW'(1);
      end
   end

   // write port select and point count
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_time  = '0;
      wr_value = req_ff.value_arg;
      count_in = count_ff;
      priority if (cmd.write_start) begin
         wr_en    = 1'b1;
         count_in = CW'(1);
      end else if (cmd.write_append) begin
         wr_en    = 1'b1;
         wr_addr  = count_ff[IW-1:0];
         wr_time  = req_ff.time_arg;
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_time_ff[wr_addr]  <= wr_time;
         mem_value_ff[wr_addr] <= wr_value;
      end
      if (rd_en) begin
         rd_time_ff  <= mem_time_ff[rd_addr];
         rd_value_ff <= mem_value_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // operand preparation
   assign range_ext = {rd_value_ff[DW-1], rd_value_ff} - {prev_value_ff[DW-1], prev_value_ff};
   assign mag_ext   = range_ext[DW] ? (~range_ext + (DW+1)'(1)) : range_ext;

   // one restoring step
   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign ge      = (shifted >= {1'b0, span_ff});
   assign diff    = shifted - {1'b0, span_ff};

   // final add or subtract
   assign q_ext   = span_zero_ff ? '0 : {1'b0, quo_ff};
   assign lo_ext  = {lo_value_ff[DW-1], lo_value_ff};
   assign sum_ext = neg_ff ? (lo_ext - q_ext) : (lo_ext + q_ext);

   always_ff @(posedge clock) begin
      j_ff <= j_in;
      if (cmd.capture) begin
         req_ff <= req_word;
      end
      if (cmd.scan_step) begin
         prev_time_ff  <= rd_time_ff;
         prev_value_ff <= rd_value_ff;
      end
      if (cmd.load_ops) begin
         span_ff      <= rd_time_ff - prev_time_ff;
         span_zero_ff <= (rd_time_ff == prev_time_ff);
         dt_ff        <= req_ff.time_arg - prev_time_ff;
         mag_ff       <= mag_ext[DW-1:0];
         neg_ff       <= range_ext[DW];
         lo_value_ff  <= prev_value_ff;
      end
      if (cmd.mul) begin
         // high half is below the span, so it seeds the remainder
         {rem_ff, quo_ff} <= dt_ff * mag_ff;
         div_cnt_ff       <= '0;
      end else if (cmd.div_step) begin
         rem_ff     <= ge ? diff[DW-1:0] : shifted[DW-1:0];
         quo_ff     <= {quo_ff[DW-2:0], ge};
         div_cnt_ff <= div_cnt_ff + VW'(1);
      end
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      rsp_in.result_value = '0;
      rsp_in.status       = plin_pkg::ST_OK;
      unique case (cmd.rsp_sel)
         plin_pkg::RSP_OK: begin
            rsp_in.status = plin_pkg::ST_OK;
         end
         plin_pkg::RSP_REJECT: begin
            rsp_in.status = plin_pkg::ST_REJECT;
         end
         plin_pkg::RSP_FEW: begin
            rsp_in.status = plin_pkg::ST_FEW;
         end
         plin_pkg::RSP_LAST: begin
            rsp_in.result_value = rd_value_ff;
         end
         plin_pkg::RSP_INTERP: begin
            rsp_in.result_value = sum_ext[DW-1:0];
         end
         default: begin
            rsp_in.status = plin_pkg::ST_OK;
         end
      endcase
   end

   assign stat.kind       = req_ff.kind;
   assign stat.count_zero = (count_ff == '0);
   assign stat.count_full = (count_ff >= CW'(plin_pkg::MAX_POINTS));
   assign stat.count_few  = (count_ff < CW'(2));
   assign stat.time_le_rd = (req_ff.time_arg <= rd_time_ff);
   assign stat.j_zero     = (j_ff == '0);
   assign stat.j_at_last  = (j_ff == last_idx);
   assign stat.div_last   = (div_cnt_ff == VW'(plin_pkg::DIV_STEPS - 1));

   assign rsp_word = rsp_ff;

endmodule

`default_nettype wire

[src/plin_ctrl.sv]
// sequencing state machine of the piecewise linear interpolator
// depends on plin_pkg
`default_nettype none

module plin_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire plin_pkg::stat_type stat,
   output plin_pkg::cmd_type       cmd
);

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_DECODE  = 9'b000000010,
      S_APP_CHK = 9'b000000100,
      S_Q_LAST  = 9'b000001000,
      S_SCAN    = 9'b000010000,
      S_MUL     = 9'b000100000,
      S_DIV     = 9'b001000000,
      S_FIN     = 9'b010000000,
      S_RESP    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.rsp_sel = plin_pkg::RSP_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            priority if (stat.kind == plin_pkg::KIND_START) begin
               cmd.write_start = 1'b1;
               cmd.rsp_load    = 1'b1;
               state_in        = S_RESP;
            end else if (stat.kind == plin_pkg::KIND_APPEND) begin
               if (stat.count_zero || stat.count_full) begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_sel  = plin_pkg::RSP_REJECT;
                  state_in     = S_RESP;
               end else begin
                  cmd.rd_last = 1'b1;
                  state_in    = S_APP_CHK;
               end
            end else if (stat.kind == plin_pkg::KIND_QUERY) begin
               if (stat.count_few) begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_sel  = plin_pkg::RSP_FEW;
                  state_in     = S_RESP;
               end else begin
                  cmd.rd_last = 1'b1;
                  state_in    = S_Q_LAST;
               end
            end else begin
               cmd.rsp_load = 1'b1;
               state_in     = S_RESP;
            end
         end
         S_APP_CHK: begin
            cmd.rsp_load = 1'b1;
            if (stat.time_le_rd) begin
               cmd.rsp_sel = plin_pkg::RSP_REJECT;
            end else begin
               cmd.write_append = 1'b1;
            end
            state_in = S_RESP;
         end
         S_Q_LAST: begin
            if (!stat.time_le_rd) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = plin_pkg::RSP_LAST;
               state_in     = S_RESP;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            priority if (stat.j_zero) begin
               cmd.scan_step = 1'b1;
            end else if (stat.time_le_rd || stat.j_at_last) begin
               cmd.load_ops = 1'b1;
               state_in     = S_MUL;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_sel  = plin_pkg::RSP_INTERP;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

`default_nettype wire

[src/piecewise_linear_interpolator.sv]
// top level of the piecewise linear interpolator: controller plus datapath
// depends on plin_pkg, plin_ctrl, plin_datapath
`default_nettype none

//  channel | handshake            | word                               | direction
//  --------+----------------------+------------------------------------+----------
//  req     | req_valid, req_ready | req_word: kind, time_arg, value_arg | in
//  rsp     | rsp_valid, rsp_ready | rsp_word: result_value, status      | out
//
// one word in flight; after acceptance the result passes through decode alone for start,
// appends rejected up front, queries on fewer than two points and unused kinds, through
// decode and a last-point check for other appends and queries past the last point; an
// interpolating query adds a table scan on one registered read port, multiply, 32 steps
// synchronous reset clears the point count and the controller, not the table contents
// a stalled result holds rsp_word in its register and req_ready stays low until taken

module piecewise_linear_interpolator (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire plin_pkg::req_type req_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output plin_pkg::rsp_type      rsp_word
);

   // command and status between the two halves
   plin_pkg::cmd_type  cmd;
   plin_pkg::stat_type stat;

   // sequencing: decode, table scan, multiply, divide, result hand-off
   plin_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // breakpoint table, arithmetic and the result register
   plin_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_word (rsp_word)
   );

endmodule

`default_nettype wire

[src/plin_checker.sv]
// port-level checks of the piecewise linear interpolator, bound to its top
// depends on plin_pkg and piecewise_linear_interpolator_assert.svh
`default_nettype none

`include "piecewise_linear_interpolator_assert.svh"

module plin_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire plin_pkg::rsp_type rsp_word
);

   logic rsp_failed;

   assign rsp_failed = (rsp_word.status != plin_pkg::ST_OK);

   // a stalled result keeps its word
   `PLIN_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

   // no new word taken while a result is pending
   `PLIN_ASSERT_IMP(a_one_in_flight, rsp_valid, !req_ready)

   // an accepted word leaves the block busy, neither ready nor showing a result
   `PLIN_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready && !rsp_valid)

   // only defined status codes
   `PLIN_ASSERT_IMP(a_status_code, rsp_valid, rsp_word.status <= plin_pkg::ST_FEW)

   // failures carry a zero value
   `PLIN_ASSERT_IMP(a_fail_zero, rsp_valid && rsp_failed, rsp_word.result_value == '0)

endmodule

bind piecewise_linear_interpolator plin_checker u_checker (.*);

`default_nettype wire
